// ===== rtl/core/spl_pkg.sv =====
package spl_pkg;

    localparam int SLOTS_DEF      = 8;
    localparam int SLOT_BYTES_DEF = 32;

    localparam int TEXT_W     = 256;
    localparam int TEXT_BYTES = TEXT_W / 8;
    localparam int MAX_OUT    = 8;

    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_DEL  = 2'd1;
    localparam logic [1:0] OP_LIST = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_FREE = 2'd1;
    localparam logic [1:0] ST_BAD_POS = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

endpackage

// ===== rtl/core/slot_pool_with_ordered_list.sv =====
// Slot pool with an ordered list of used slots.
// Input: an item is taken when start is high and busy is low. Opcode add
// takes the top free slot, stores the text up to its first zero byte and puts
// the slot at list position 0; delete frees the entry at a list position;
// list emits up to eight entries, newest first.
// Output: each result is held for one cycle with o_valid high; o_last marks
// the final result of an item. The receiver cannot stall, so no back-pressure.
// Timing: a rejected add, delete or list keeps busy low and its result
// appears in the next cycle; opcode 3 keeps busy low and gives no result.
// Add reads the free stack top, then writes both memories and its result.
// Delete moves each later entry up one place in the order memory, then pushes
// the slot. List emits one per cycle after a fill (order read, then text read).
// State lives in a list memory (free stack and circular order list) and a
// text memory, both with registered read data.
// Reset: all slots free, highest slot on top, list empty; no clearing pass.
module slot_pool_with_ordered_list #(
    parameter int SLOTS      = spl_pkg::SLOTS_DEF,
    parameter int SLOT_BYTES = spl_pkg::SLOT_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_position,
    input  logic [63:0] i_text_word0,
    input  logic [63:0] i_text_word1,
    input  logic [63:0] i_text_word2,
    input  logic [63:0] i_text_word3,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [2:0]  o_slot_index,
    output logic [2:0]  o_list_position,
    output logic [63:0] o_out_word0,
    output logic [63:0] o_out_word1,
    output logic [63:0] o_out_word2,
    output logic [63:0] o_out_word3,
    output logic        o_last
);
    import spl_pkg::*;

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int MA = SW + 1;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_ADD   = 6'b000010,
        S_DEL   = 6'b000100,
        S_SHIFT = 6'b001000,
        S_PUSH  = 6'b010000,
        S_LIST  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [CW-1:0]     r_free, n_free;
    logic [CW-1:0]     r_used, n_used;
    logic [SW-1:0]     r_head, n_head;
    logic [SLOTS-1:0]  r_fs_vld;
    logic [CW-1:0]     r_i, n_i;
    logic [SW-1:0]     r_fi, n_fi;
    logic [SW-1:0]     r_slot, n_slot;
    logic [TEXT_W-1:0] r_text, n_text;
    logic [3:0]        r_n, n_n;
    logic [3:0]        r_k, n_k;
    logic              r_p1v, n_p1v;
    logic [2:0]        r_p1pos, n_p1pos;
    logic              r_p2v, n_p2v;
    logic [2:0]        r_p2pos, n_p2pos;
    logic [SW-1:0]     r_p2slot, n_p2slot;

    // list memory: lower half free stack, upper half circular order list
    logic [SW-1:0] m_list [2**MA];
    logic [SW-1:0] r_mq;
    logic          mem_re, mem_we;
    logic [MA-1:0] mem_raddr, mem_waddr;
    logic [SW-1:0] mem_wdata;

    logic              txt_we, txt_re;
    logic [SW-1:0]     txt_wslot, txt_rslot;
    logic [TEXT_W-1:0] txt_q;

    logic              push_vld;
    logic              emit;
    logic [1:0]        e_status;
    logic [SW-1:0]     e_slot;
    logic [2:0]        e_pos;
    logic [TEXT_W-1:0] e_text;
    logic              e_last;

    logic              r_valid;
    logic [1:0]        r_status;
    logic [2:0]        r_slot_index;
    logic [2:0]        r_list_position;
    logic [TEXT_W-1:0] r_out_text;
    logic              r_last;

    logic [SW-1:0] head_m1;
    logic [SW-1:0] add_slot;
    logic [CW-1:0] ip1, ip2;
    logic [7:0]    used8;

    function automatic logic [SW-1:0] phys(input logic [SW-1:0] head,
                                           input logic [CW-1:0] x);
        logic [CW:0] s;
        s = (CW+1)'(head) + (CW+1)'(x);
        if (s >= (CW+1)'(SLOTS)) begin
            s = s - (CW+1)'(SLOTS);
        end
        return s[SW-1:0];
    endfunction

    assign head_m1  = (r_head == '0) ? SW'(SLOTS - 1) : r_head - SW'(1);
    assign add_slot = r_fs_vld[r_fi] ? r_mq : r_fi;
    assign ip1      = r_i + CW'(1);
    assign ip2      = r_i + CW'(2);
    assign used8    = 8'(r_used);

    always_comb begin
        n_state  = r_state;
        n_free   = r_free;
        n_used   = r_used;
        n_head   = r_head;
        n_i      = r_i;
        n_fi     = r_fi;
        n_slot   = r_slot;
        n_text   = r_text;
        n_n      = r_n;
        n_k      = r_k;
        n_p1v    = 1'b0;
        n_p1pos  = r_p1pos;
        n_p2v    = 1'b0;
        n_p2pos  = r_p2pos;
        n_p2slot = r_p2slot;

        mem_re    = 1'b0;
        mem_raddr = '0;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        push_vld  = 1'b0;
        txt_we    = 1'b0;
        txt_wslot = '0;
        txt_re    = 1'b0;
        txt_rslot = '0;

        emit     = 1'b0;
        e_status = ST_OK;
        e_slot   = '0;
        e_pos    = '0;
        e_text   = '0;
        e_last   = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    unique case (i_opcode)
                        OP_ADD: begin
                            if (r_free == '0) begin
                                emit     = 1'b1;
                                e_status = ST_NO_FREE;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = {1'b0, SW'(r_free - CW'(1))};
                                n_fi      = SW'(r_free - CW'(1));
                                n_text    = {i_text_word3, i_text_word2,
                                             i_text_word1, i_text_word0};
                                n_state   = S_ADD;
                            end
                        end
                        OP_DEL: begin
                            if (i_position >= used8) begin
                                emit     = 1'b1;
                                e_status = ST_BAD_POS;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = {1'b1, phys(r_head, CW'(i_position))};
                                n_i       = CW'(i_position);
                                n_state   = S_DEL;
                            end
                        end
                        OP_LIST: begin
                            if (r_used == '0) begin
                                emit     = 1'b1;
                                e_status = ST_EMPTY;
                            end else begin
                                n_n     = (used8 > 8'(MAX_OUT)) ? 4'(MAX_OUT) : 4'(used8);
                                n_k     = '0;
                                n_state = S_LIST;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_ADD: begin
                mem_we    = 1'b1;
                mem_waddr = {1'b1, head_m1};
                mem_wdata = add_slot;
                txt_we    = 1'b1;
                txt_wslot = add_slot;
                n_head    = head_m1;
                n_free    = r_free - CW'(1);
                n_used    = r_used + CW'(1);
                emit      = 1'b1;
                e_slot    = add_slot;
                n_state   = S_IDLE;
            end
            S_DEL: begin
                n_slot = r_mq;
                if (ip1 < r_used) begin
                    mem_re    = 1'b1;
                    mem_raddr = {1'b1, phys(r_head, ip1)};
                    n_state   = S_SHIFT;
                end else begin
                    n_state = S_PUSH;
                end
            end
            S_SHIFT: begin
                mem_we    = 1'b1;
                mem_waddr = {1'b1, phys(r_head, r_i)};
                mem_wdata = r_mq;
                n_i       = ip1;
                if (ip2 < r_used) begin
                    mem_re    = 1'b1;
                    mem_raddr = {1'b1, phys(r_head, ip2)};
                end else begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                mem_we    = 1'b1;
                mem_waddr = {1'b0, SW'(r_free)};
                mem_wdata = r_slot;
                push_vld  = 1'b1;
                n_free    = r_free + CW'(1);
                n_used    = r_used - CW'(1);
                emit      = 1'b1;
                e_slot    = r_slot;
                n_state   = S_IDLE;
            end
            S_LIST: begin
                if (r_k < r_n) begin
                    mem_re    = 1'b1;
                    mem_raddr = {1'b1, phys(r_head, CW'(r_k))};
                    n_k       = r_k + 4'd1;
                    n_p1v     = 1'b1;
                    n_p1pos   = 3'(r_k);
                end
                if (r_p1v) begin
                    txt_re    = 1'b1;
                    txt_rslot = r_mq;
                    n_p2v     = 1'b1;
                    n_p2pos   = r_p1pos;
                    n_p2slot  = r_mq;
                end
                if (r_p2v) begin
                    emit   = 1'b1;
                    e_slot = r_p2slot;
                    e_pos  = r_p2pos;
                    e_text = txt_q;
                    e_last = (({1'b0, r_p2pos} + 4'd1) == r_n);
                    if (e_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_free   <= CW'(SLOTS);
            r_used   <= '0;
            r_head   <= '0;
            r_fs_vld <= '0;
            r_p1v    <= 1'b0;
            r_p2v    <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_free  <= n_free;
            r_used  <= n_used;
            r_head  <= n_head;
            r_p1v   <= n_p1v;
            r_p2v   <= n_p2v;
            r_valid <= emit;
            if (push_vld) begin
                r_fs_vld[SW'(r_free)] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_i      <= n_i;
        r_fi     <= n_fi;
        r_slot   <= n_slot;
        r_text   <= n_text;
        r_n      <= n_n;
        r_k      <= n_k;
        r_p1pos  <= n_p1pos;
        r_p2pos  <= n_p2pos;
        r_p2slot <= n_p2slot;
        if (emit) begin
            r_status        <= e_status;
            r_slot_index    <= 3'(e_slot);
            r_list_position <= e_pos;
            r_out_text      <= e_text;
            r_last          <= e_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            m_list[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_mq <= m_list[mem_raddr];
        end
    end

    spl_text_store #(
        .SLOTS      (SLOTS),
        .SLOT_BYTES (SLOT_BYTES)
    ) u_text (
        .i_clk     (i_clk),
        .i_wr_en   (txt_we),
        .i_wr_slot (txt_wslot),
        .i_wr_text (r_text),
        .i_rd_en   (txt_re),
        .i_rd_slot (txt_rslot),
        .o_rd_text (txt_q)
    );

    assign busy            = (r_state != S_IDLE);
    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_slot_index    = r_slot_index;
    assign o_list_position = r_list_position;
    assign o_out_word0     = r_out_text[63:0];
    assign o_out_word1     = r_out_text[127:64];
    assign o_out_word2     = r_out_text[191:128];
    assign o_out_word3     = r_out_text[255:192];
    assign o_last          = r_last;

endmodule

// ===== rtl/core/spl_text_store.sv =====
module spl_text_store #(
    parameter int SLOTS      = spl_pkg::SLOTS_DEF,
    parameter int SLOT_BYTES = spl_pkg::SLOT_BYTES_DEF,
    localparam int SW        = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [SW-1:0]               i_wr_slot,
    input  logic [spl_pkg::TEXT_W-1:0]  i_wr_text,
    input  logic                        i_rd_en,
    input  logic [SW-1:0]               i_rd_slot,
    output logic [spl_pkg::TEXT_W-1:0]  o_rd_text
);
    import spl_pkg::*;

    localparam int DBW = 8 * SLOT_BYTES;
    localparam logic [TEXT_BYTES-1:0] ONE = TEXT_BYTES'(1);

    logic [DBW-1:0]        m_text [SLOTS];
    logic [DBW-1:0]        r_q;
    logic [TEXT_BYTES-1:0] zb;
    logic [DBW-1:0]        wdata;

    // bytes from the first zero byte onwards are cleared
    always_comb begin
        for (int b = 0; b < TEXT_BYTES; b++) begin
            zb[b] = (i_wr_text[8*b +: 8] == 8'h00);
        end
        for (int b = 0; b < SLOT_BYTES; b++) begin
            if (~|(zb & ((ONE << (b + 1)) - ONE))) begin
                wdata[8*b +: 8] = i_wr_text[8*b +: 8];
            end else begin
                wdata[8*b +: 8] = 8'h00;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            m_text[i_wr_slot] <= wdata;
        end
        if (i_rd_en) begin
            r_q <= m_text[i_rd_slot];
        end
    end

    assign o_rd_text = TEXT_W'(r_q);

endmodule

// ===== dv/slot_pool_with_ordered_list_tb.sv =====
`timescale 1ns / 1ps

module slot_pool_with_ordered_list_tb;
    import spl_pkg::*;

    localparam logic [1:0] OP_NONE   = 2'd3;
    localparam int         WD_LIMIT  = 2000;
    localparam int         TAIL_WAIT = 16;

    typedef struct packed {
        logic [1:0]   status;
        logic [2:0]   slot;
        logic [2:0]   lpos;
        logic [255:0] text;
        logic         last;
    } t_pool_reply;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_opcode = OP_ADD;
    logic [7:0]  i_position = '0;
    logic [63:0] i_text_word0 = '0;
    logic [63:0] i_text_word1 = '0;
    logic [63:0] i_text_word2 = '0;
    logic [63:0] i_text_word3 = '0;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [2:0]  o_slot_index;
    logic [2:0]  o_list_position;
    logic [63:0] o_out_word0;
    logic [63:0] o_out_word1;
    logic [63:0] o_out_word2;
    logic [63:0] o_out_word3;
    logic        o_last;

    // shadow of the pool
    logic [2:0]   free_stack [SLOTS_DEF];
    int           free_cnt;
    logic [2:0]   used_order [SLOTS_DEF];
    int           used_cnt;
    logic [255:0] slot_text [SLOTS_DEF];

    t_pool_reply pending_replies [$];
    int          err_cnt = 0;
    int          idle_pct = 0;
    int          quiet_cycles = 0;

    slot_pool_with_ordered_list u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_opcode        (i_opcode),
        .i_position      (i_position),
        .i_text_word0    (i_text_word0),
        .i_text_word1    (i_text_word1),
        .i_text_word2    (i_text_word2),
        .i_text_word3    (i_text_word3),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_slot_index    (o_slot_index),
        .o_list_position (o_list_position),
        .o_out_word0     (o_out_word0),
        .o_out_word1     (o_out_word1),
        .o_out_word2     (o_out_word2),
        .o_out_word3     (o_out_word3),
        .o_last          (o_last)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic push_reply(input logic [1:0] st, input logic [2:0] slot,
                              input logic [2:0] lpos, input logic [255:0] text,
                              input logic last);
        t_pool_reply r;
        r = '{status: st, slot: slot, lpos: lpos, text: text, last: last};
        pending_replies.insert(pending_replies.size(), r);
    endtask

    task automatic pool_apply(input logic [1:0] op, input logic [7:0] pos,
                              input logic [255:0] text);
        logic [255:0] kept;
        logic [2:0]   slot;
        bit           ended;
        int           i;
        int           n;
        kept  = '0;
        ended = 1'b0;
        case (op)
            OP_ADD: begin
                if (free_cnt == 0) begin
                    push_reply(ST_NO_FREE, '0, '0, '0, 1'b1);
                end else begin
                    free_cnt--;
                    slot = free_stack[free_cnt];
                    for (i = 0; i < SLOT_BYTES_DEF && i < TEXT_BYTES; i++) begin
                        if (text[i*8 +: 8] == 8'h00)
                            ended = 1'b1;
                        if (!ended)
                            kept[i*8 +: 8] = text[i*8 +: 8];
                    end
                    slot_text[slot] = kept;
                    for (i = used_cnt; i > 0; i--)
                        used_order[i] = used_order[i-1];
                    used_order[0] = slot;
                    used_cnt++;
                    push_reply(ST_OK, slot, '0, '0, 1'b1);
                end
            end
            OP_DEL: begin
                if (pos >= used_cnt) begin
                    push_reply(ST_BAD_POS, '0, '0, '0, 1'b1);
                end else begin
                    slot = used_order[pos];
                    for (i = int'(pos); i + 1 < used_cnt; i++)
                        used_order[i] = used_order[i+1];
                    used_cnt--;
                    free_stack[free_cnt] = slot;
                    free_cnt++;
                    push_reply(ST_OK, slot, '0, '0, 1'b1);
                end
            end
            OP_LIST: begin
                n = (used_cnt < MAX_OUT) ? used_cnt : MAX_OUT;
                if (n == 0)
                    push_reply(ST_EMPTY, '0, '0, '0, 1'b1);
                for (i = 0; i < n; i++)
                    push_reply(ST_OK, used_order[i], i[2:0], slot_text[used_order[i]],
                               i + 1 == n);
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [255:0] got,
                                   input logic [255:0] want);
        $display("%0t ERROR %s: got %0h, want %0h", $time, what, got, want);
        err_cnt++;
    endtask

    always @(posedge i_clk) begin : result_check
        t_pool_reply got;
        t_pool_reply want;
        if (i_rst_n && o_valid === 1'b1) begin
            got = {o_status, o_slot_index, o_list_position,
                   o_out_word3, o_out_word2, o_out_word1, o_out_word0, o_last};
            if (pending_replies.size() == 0) begin
                report_mismatch("unexpected result, status", 256'(got.status), '0);
            end else begin
                want = pending_replies.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", 256'(got.status), 256'(want.status));
                if (got.slot !== want.slot)
                    report_mismatch("slot_index", 256'(got.slot), 256'(want.slot));
                if (got.lpos !== want.lpos)
                    report_mismatch("list_position", 256'(got.lpos), 256'(want.lpos));
                if (got.text !== want.text)
                    report_mismatch("out_words", got.text, want.text);
                if (got.last !== want.last)
                    report_mismatch("last", 256'(got.last), 256'(want.last));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_valid === 1'b1)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WD_LIMIT) begin
            $display("slot_pool_with_ordered_list_tb: done, errors");
            $finish;
        end
    end

    // start is left high on return; the next send_item or drain_replies drives it again
    task automatic send_item(input logic [1:0] op, input logic [7:0] pos,
                             input logic [255:0] text);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start        <= 1'b1;
        i_opcode     <= op;
        i_position   <= pos;
        i_text_word0 <= text[63:0];
        i_text_word1 <= text[127:64];
        i_text_word2 <= text[191:128];
        i_text_word3 <= text[255:192];
        @(posedge i_clk);
        while (busy !== 1'b0)
            @(posedge i_clk);
        pool_apply(op, pos, text);
    endtask

    task automatic drain_replies();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_replies.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);
    endtask

    function automatic logic [255:0] rand_text();
        logic [255:0] t;
        int           k;
        int           mode;
        for (k = 0; k < 8; k++)
            t[k*32 +: 32] = $urandom;
        mode = $urandom_range(0, 2);
        if (mode == 0) begin
            for (k = 0; k < TEXT_BYTES; k++)
                if (t[k*8 +: 8] == 8'h00)
                    t[k*8 +: 8] = 8'h80;
        end else if (mode == 1) begin
            k = $urandom_range(0, TEXT_BYTES - 1);
            t[k*8 +: 8] = 8'h00;
        end
        return t;
    endfunction

    task automatic test_empty_pool();
        send_item(OP_LIST, 8'd0, '0);
        send_item(OP_DEL, 8'd0, '0);
        send_item(OP_DEL, 8'd255, '1);
        drain_replies();
    endtask

    task automatic test_add_text_forms();
        logic [255:0] t;
        send_item(OP_ADD, 8'd0, '1);
        t = '1;
        t[7:0] = 8'h00;
        send_item(OP_ADD, 8'd0, t);
        t = rand_text() | {32{8'h01}};
        t[13*8 +: 8] = 8'h00;
        send_item(OP_ADD, 8'd0, t);
        t = '1;
        t[255:248] = 8'h00;
        send_item(OP_ADD, 8'd0, t);
        send_item(OP_ADD, 8'd0, '0);
        send_item(OP_LIST, 8'd0, '0);
        drain_replies();
    endtask

    task automatic test_pool_full();
        repeat (3) send_item(OP_ADD, 8'd0, rand_text());
        send_item(OP_ADD, 8'd0, rand_text());
        send_item(OP_ADD, 8'd255, '1);
        send_item(OP_LIST, 8'd0, '0);
        drain_replies();
    endtask

    task automatic test_delete_positions();
        send_item(OP_DEL, 8'd7, '0);
        send_item(OP_DEL, 8'd0, '0);
        send_item(OP_DEL, 8'd3, '0);
        send_item(OP_DEL, 8'd5, '0);
        send_item(OP_DEL, 8'd200, '0);
        send_item(OP_LIST, 8'd0, '0);
        drain_replies();
    endtask

    task automatic test_ignored_opcode();
        send_item(OP_NONE, 8'd255, '1);
        send_item(OP_LIST, 8'd0, '0);
        drain_replies();
    endtask

    // alternating fill and drain bias so the pool swings between empty and full
    task automatic test_random_traffic(input int pct, input int n_items);
        logic [1:0] op;
        logic [7:0] pos;
        int         done;
        int         add_w;
        int         r;
        bit         flip;
        idle_pct = pct;
        done     = 0;
        flip     = 1'($urandom_range(0, 1));
        while (done < n_items) begin
            add_w = (((done / 20) % 2) ^ flip) ? 62 : 25;
            r     = $urandom_range(0, 99);
            if (r < add_w)
                op = OP_ADD;
            else if (r < 85)
                op = OP_DEL;
            else if (r < 96)
                op = OP_LIST;
            else
                op = OP_NONE;
            if (op == OP_DEL && used_cnt != 0 && $urandom_range(0, 99) < 85)
                pos = 8'($urandom_range(0, used_cnt - 1));
            else
                pos = 8'($urandom_range(0, 255));
            send_item(op, pos, rand_text());
            if (op != OP_NONE)
                done++;
            if ($urandom_range(0, 39) == 0)
                drain_replies();
        end
        drain_replies();
    endtask

    initial begin
        int i;
        for (i = 0; i < SLOTS_DEF; i++) begin
            free_stack[i] = i[2:0];
            used_order[i] = '0;
            slot_text[i]  = '0;
        end
        free_cnt = SLOTS_DEF;
        used_cnt = 0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_pool();
        test_add_text_forms();
        test_pool_full();
        test_delete_positions();
        test_ignored_opcode();
        test_random_traffic(15, 60);
        test_random_traffic(77, 60);
        test_random_traffic(0, 60);

        if (err_cnt == 0)
            $display("slot_pool_with_ordered_list_tb: done, clean");
        else
            $display("slot_pool_with_ordered_list_tb: done, errors");
        $finish;
    end

endmodule
